/* rtl/modbus_rtu_master_framer_assert.svh */
// Assertion macros for the Modbus RTU master framer.
`ifndef MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH

// ante implies cons on the same edge
`define MRTU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond never holds
`define MRTU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/mrtu_pkg.sv */
// Shared types, constants and CRC function for the Modbus RTU master framer.
`default_nettype none

package mrtu_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FC_READ   = 8'h03;
  localparam logic [7:0]  FC_PRESET = 8'h06;

  localparam int CovW    = 9;
  localparam int QDepth  = 4;
  localparam int NReqB   = 8;
  localparam int NCrcB   = 6;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CRC   = 2'd1,
    ST_FUNC  = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  // command word between front and back
  typedef struct packed {
    logic        kind;
    logic [7:0]  slave_id;
    logic        function_sel;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    status_t     status;
    logic [7:0]  resp_function;
    logic [7:0]  rx_length;
  } cmd_t;

  typedef struct packed {
    logic mid_request;
  } back_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/modbus_rtu_master_framer.sv */
// Top level of the Modbus RTU master framer.
//
//  channel  | handshake          | words
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | mode, slave_id, function_sel, reg_address,
//           |                    | reg_value, rx_byte, rx_end
//  result   | empty / pop        | kind, tx_byte, tx_last, status,
//           |                    | resp_function, rx_length
//
// Input side takes one word per cycle while full is low; a received byte is folded
// into the CRC in the cycle it is accepted. A request yields eight result words,
// one per cycle unless pop stalls, set by the back-end byte sequencer. A verdict
// yields one word. full rises when the four-entry command queue is full; the result
// register holds its word while pop is low. Synchronous reset clears control state.
`default_nettype none

module modbus_rtu_master_framer #(
  parameter int MAX_FRAME = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode,
  input  wire logic [7:0]  slave_id,
  input  wire logic        function_sel,
  input  wire logic [15:0] reg_address,
  input  wire logic [15:0] reg_value,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        rx_end,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind,
  output logic [7:0]       tx_byte,
  output logic             tx_last,
  output logic [1:0]       status,
  output logic [7:0]       resp_function,
  output logic [7:0]       rx_length
);

  logic                  take;
  logic                  q_push, q_full, q_pop, q_empty;
  mrtu_pkg::cmd_t        q_wdata, q_rdata;
  mrtu_pkg::back_stat_t  bstat;

  assign take = push && !full;
  assign full = q_full;

  mrtu_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .mode         (mode),
    .slave_id     (slave_id),
    .function_sel (function_sel),
    .reg_address  (reg_address),
    .reg_value    (reg_value),
    .rx_byte      (rx_byte),
    .rx_end       (rx_end),
    .cmd_push     (q_push),
    .cmd          (q_wdata)
  );

  mrtu_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mrtu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_rdata),
    .head_empty    (q_empty),
    .head_pop      (q_pop),
    .pop           (pop),
    .empty         (empty),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .tx_last       (tx_last),
    .status        (status),
    .resp_function (resp_function),
    .rx_length     (rx_length),
    .stat          (bstat)
  );

  `include "modbus_rtu_master_framer_assert.svh"

  `MRTU_ASSERT_NEVER(a_push_when_full, q_push && q_full, "push into full queue")
  `MRTU_ASSERT_IMP(a_mid_req_has_head, bstat.mid_request, !q_empty, "request lost its entry")
  `MRTU_ASSERT_IMP(a_verdict_clean, !empty && kind, tx_byte == 8'h00 && !tx_last, "verdict tx data")
  `MRTU_ASSERT_IMP(a_tx_clean, !empty && !kind, status == mrtu_pkg::ST_OK && rx_length == 8'h00, "tx verdict data")

endmodule

`default_nettype wire

/* rtl/mrtu_front.sv */
// Front end: takes input words, runs the receive CRC and issues commands.
`default_nettype none

module mrtu_front #(
  parameter int MAX_FRAME = 128
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic                mode,
  input  wire logic [7:0]          slave_id,
  input  wire logic                function_sel,
  input  wire logic [15:0]         reg_address,
  input  wire logic [15:0]         reg_value,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                rx_end,
  output logic                     cmd_push,
  output mrtu_pkg::cmd_t           cmd
);

  localparam int IdxW = $clog2(MAX_FRAME + 1);

  logic [15:0]                     crc_running, crc_running_next;
  logic [15:0]                     crc_captured, crc_captured_next;
  logic [IdxW-1:0]                 byte_index, byte_index_next;
  logic [mrtu_pkg::CovW-1:0]       covered_length, covered_length_next;
  logic [7:0]                      func_code, func_code_next;
  logic [7:0]                      second_last_byte, second_last_byte_next;
  logic [7:0]                      last_byte, last_byte_next;

  logic [mrtu_pkg::CovW-1:0]       idx9, len9;
  logic [15:0]                     crc_upd;
  mrtu_pkg::status_t               st;

  assign idx9    = mrtu_pkg::CovW'(byte_index);
  assign crc_upd = mrtu_pkg::crc_byte(crc_running, rx_byte);

  // receive state update for one byte (values as left after this byte)
  always_comb begin
    crc_running_next      = crc_running;
    crc_captured_next     = crc_captured;
    byte_index_next       = byte_index;
    covered_length_next   = covered_length;
    func_code_next        = func_code;
    second_last_byte_next = second_last_byte;
    last_byte_next        = last_byte;
    if (byte_index < IdxW'(MAX_FRAME)) begin
      if (idx9 == mrtu_pkg::CovW'(1)) begin
        func_code_next      = rx_byte;
        covered_length_next = (rx_byte == mrtu_pkg::FC_PRESET) ?
                              mrtu_pkg::CovW'(6) : '0;
      end else if (idx9 == mrtu_pkg::CovW'(2) && func_code == mrtu_pkg::FC_READ) begin
        covered_length_next = mrtu_pkg::CovW'(3) + mrtu_pkg::CovW'(rx_byte);
      end
      if (idx9 < mrtu_pkg::CovW'(3) || idx9 < covered_length_next) begin
        crc_running_next = crc_upd;
        if (idx9 + mrtu_pkg::CovW'(1) == covered_length_next) crc_captured_next = crc_upd;
      end
      second_last_byte_next = last_byte;
      last_byte_next        = rx_byte;
      byte_index_next       = IdxW'(idx9 + mrtu_pkg::CovW'(1));
    end
  end

  assign len9 = mrtu_pkg::CovW'(byte_index_next);

  always_comb begin
    if (len9 < mrtu_pkg::CovW'(3)) begin
      st = mrtu_pkg::ST_SHORT;
    end else if (func_code_next != mrtu_pkg::FC_READ &&
                 func_code_next != mrtu_pkg::FC_PRESET) begin
      st = mrtu_pkg::ST_FUNC;
    end else if (len9 < covered_length_next) begin
      st = mrtu_pkg::ST_SHORT;
    end else if (crc_captured_next[7:0] == second_last_byte_next &&
                 crc_captured_next[15:8] == last_byte_next) begin
      st = mrtu_pkg::ST_OK;
    end else begin
      st = mrtu_pkg::ST_CRC;
    end
  end

  always_comb begin
    cmd_push          = take && (!mode || rx_end);
    cmd.kind          = mode ? mrtu_pkg::KIND_VERDICT : mrtu_pkg::KIND_TX;
    cmd.slave_id      = slave_id;
    cmd.function_sel  = function_sel;
    cmd.reg_address   = reg_address;
    cmd.reg_value     = reg_value;
    cmd.status        = st;
    cmd.resp_function = (len9 >= mrtu_pkg::CovW'(2)) ? func_code_next : 8'h00;
    cmd.rx_length     = len9[8] ? 8'hFF : len9[7:0];
  end

  always_ff @(posedge clk) begin
    // a request or a closed frame restarts reception
    if (rst || (take && (!mode || rx_end))) begin
      crc_running      <= mrtu_pkg::CRC_INIT;
      crc_captured     <= '0;
      byte_index       <= '0;
      covered_length   <= '0;
      func_code        <= '0;
      second_last_byte <= '0;
      last_byte        <= '0;
    end else if (take) begin
      crc_running      <= crc_running_next;
      crc_captured     <= crc_captured_next;
      byte_index       <= byte_index_next;
      covered_length   <= covered_length_next;
      func_code        <= func_code_next;
      second_last_byte <= second_last_byte_next;
      last_byte        <= last_byte_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mrtu_cmd_fifo.sv */
// Short command queue between front and back.
`default_nettype none

module mrtu_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mrtu_pkg::cmd_t wdata,
  output logic                full,
  input  wire logic           pop,
  output mrtu_pkg::cmd_t      rdata,
  output logic                empty
);

  localparam int PtrW = $clog2(mrtu_pkg::QDepth);
  localparam int CntW = $clog2(mrtu_pkg::QDepth + 1);

  mrtu_pkg::cmd_t   mem [mrtu_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push, do_pop;

  assign full    = (count == CntW'(mrtu_pkg::QDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

/* rtl/mrtu_back.sv */
// Back end: serializes request frames with CRC and emits verdicts.
`default_nettype none

module mrtu_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mrtu_pkg::cmd_t   head,
  input  wire logic             head_empty,
  output logic                  head_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic                  kind,
  output logic [7:0]            tx_byte,
  output logic                  tx_last,
  output logic [1:0]            status,
  output logic [7:0]            resp_function,
  output logic [7:0]            rx_length,
  output mrtu_pkg::back_stat_t  stat
);

  localparam int StepW = $clog2(mrtu_pkg::NReqB);
  localparam logic [StepW-1:0] LastStep = StepW'(mrtu_pkg::NReqB - 1);

  logic [StepW-1:0] step;
  logic [15:0]      crc;
  logic             out_valid;
  logic             advance;
  logic [7:0]       cur_byte;
  logic [7:0]       fc;

  assign advance = !head_empty && (!out_valid || pop);
  assign fc      = head.function_sel ? mrtu_pkg::FC_PRESET : mrtu_pkg::FC_READ;

  always_comb begin
    case (step)
      3'd0:    cur_byte = head.slave_id;
      3'd1:    cur_byte = fc;
      3'd2:    cur_byte = head.reg_address[15:8];
      3'd3:    cur_byte = head.reg_address[7:0];
      3'd4:    cur_byte = head.reg_value[15:8];
      3'd5:    cur_byte = head.reg_value[7:0];
      3'd6:    cur_byte = crc[7:0];
      default: cur_byte = crc[15:8];
    endcase
  end

  assign head_pop = advance &&
                    (head.kind == mrtu_pkg::KIND_VERDICT || step == LastStep);
  assign empty            = !out_valid;
  assign stat.mid_request = (step != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
      crc       <= mrtu_pkg::CRC_INIT;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (advance && head.kind == mrtu_pkg::KIND_TX) begin
        if (step == LastStep) begin
          step <= '0;
          crc  <= mrtu_pkg::CRC_INIT;
        end else begin
          step <= step + 1'b1;
          if (step < StepW'(mrtu_pkg::NCrcB)) crc <= mrtu_pkg::crc_byte(crc, cur_byte);
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (advance) begin
      kind <= head.kind;
      if (head.kind == mrtu_pkg::KIND_VERDICT) begin
        tx_byte       <= 8'h00;
        tx_last       <= 1'b0;
        status        <= head.status;
        resp_function <= head.resp_function;
        rx_length     <= head.rx_length;
      end else begin
        tx_byte       <= cur_byte;
        tx_last       <= (step == LastStep);
        status        <= mrtu_pkg::ST_OK;
        resp_function <= 8'h00;
        rx_length     <= 8'h00;
      end
    end
  end

endmodule

`default_nettype wire
